/* rtl/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the shifting FIFO with search
// Request kinds, status codes and the storage geometry of the queue.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int DEPTH   = 8;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int REQ_IDX_W = 3;
  localparam int FIND_W  = 3;
  localparam int FILL_W  = 4;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_SRCH = 2'd2,
    REQ_UPD  = 2'd3
  } req_kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADINDEX = 3'd4
  } status_e;

endpackage

/* rtl/sfs_ifs.sv */
// ----------------------------------------------------------------------------
// sfs_ifs: request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sfs_req_if;
  logic                              valid;
  logic                              ready;
  sfs_pkg::req_kind_e                req_type;
  logic signed [sfs_pkg::DATA_W-1:0] req_value;
  logic [sfs_pkg::REQ_IDX_W-1:0]     req_index;

  modport source (output valid, req_type, req_value, req_index, input ready);
  modport sink   (input valid, req_type, req_value, req_index, output ready);
endinterface

interface sfs_rsp_if;
  logic                              valid;
  logic                              ready;
  sfs_pkg::status_e                  status;
  logic signed [sfs_pkg::DATA_W-1:0] out_value;
  logic [sfs_pkg::FIND_W-1:0]        found_index;
  logic [sfs_pkg::FILL_W-1:0]        fill_count;

  modport source (output valid, status, out_value, found_index, fill_count, input ready);
  modport sink   (input valid, status, out_value, found_index, fill_count, output ready);
endinterface

/* rtl/sfs_ram.sv */
// ----------------------------------------------------------------------------
// sfs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/shifting_fifo_with_search_unit.sv */
// ----------------------------------------------------------------------------
// shifting_fifo_with_search_unit: queue with dequeue shift, search and update
//
//   channel | dir | payload
//   req_i   | in  | req_type, req_value, req_index
//   rsp_o   | out | status, out_value, found_index, fill_count
//
// Enqueue and update go straight to the finish step. Dequeue moves each
// remaining entry one slot toward the head, search walks from the head to a hit
// or the tail; the single RAM read port and the one comparator walk one slot a cycle.
// Reset empties the queue at once; slot contents are not cleared.
// req_i.ready is high only between requests. A result waits in the output
// register while the next request is worked on; the finish step holds until
// that register is free.
// ----------------------------------------------------------------------------
module shifting_fifo_with_search_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfs_req_if.sink   req_i,
  sfs_rsp_if.source rsp_o
);
  import sfs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SRCH,
    S_FIN
  } state_e;

  state_e                  state_q;
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        ptr_q;
  logic [DATA_W-1:0]       key_q;
  status_e                 res_status_q;
  logic [DATA_W-1:0]       res_value_q;
  logic [FIND_W-1:0]       res_found_q;

  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [DATA_W-1:0]       out_value_q;
  logic [FIND_W-1:0]       out_found_q;
  logic [FILL_W-1:0]       out_fill_q;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]       ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]       ram_rdata;
  logic                    req_acc;
  logic                    idx_ok;
  logic                    key_hit;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign idx_ok      = CNT_W'(req_i.req_index) < count_q;
  assign key_hit     = (ram_rdata == key_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = $unsigned(req_i.req_value);
    ram_raddr = (state_q == S_IDLE) ? '0 : ptr_q[IDX_W-1:0];
    if (req_acc) begin
      case (req_i.req_type)
        REQ_ENQ: begin
          ram_we    = (count_q < CNT_W'(DEPTH));
          ram_waddr = count_q[IDX_W-1:0];
        end
        REQ_UPD: begin
          ram_we    = idx_ok;
          ram_waddr = IDX_W'(req_i.req_index);
        end
        default: ;
      endcase
    end else if (state_q == S_SHIFT && ptr_q >= CNT_W'(2)) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(ptr_q - CNT_W'(2));
      ram_wdata = ram_rdata;
    end
  end

  sfs_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
      out_status_q <= ST_OK;
    end else begin
      if (out_valid_q && rsp_o.ready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            ptr_q       <= CNT_W'(1);
            key_q       <= $unsigned(req_i.req_value);
            res_value_q <= '0;
            res_found_q <= '0;
            case (req_i.req_type)
              REQ_ENQ: begin
                if (count_q < CNT_W'(DEPTH)) begin
                  res_status_q <= ST_OK;
                  count_q      <= count_q + CNT_W'(1);
                end else begin
                  res_status_q <= ST_FULL;
                end
                state_q <= S_FIN;
              end
              REQ_DEQ: begin
                if (count_q == '0) begin
                  res_status_q <= ST_EMPTY;
                  state_q      <= S_FIN;
                end else begin
                  res_status_q <= ST_OK;
                  state_q      <= S_SHIFT;
                end
              end
              REQ_SRCH: begin
                if (count_q == '0) begin
                  res_status_q <= ST_NOTFOUND;
                  state_q      <= S_FIN;
                end else begin
                  state_q <= S_SRCH;
                end
              end
              default: begin
                res_status_q <= idx_ok ? ST_OK : ST_BADINDEX;
                state_q      <= S_FIN;
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (ptr_q == CNT_W'(1)) begin
            res_value_q <= ram_rdata;
          end
          if (ptr_q == count_q) begin
            count_q <= count_q - CNT_W'(1);
            state_q <= S_FIN;
          end else begin
            ptr_q <= ptr_q + CNT_W'(1);
          end
        end
        S_SRCH: begin
          if (key_hit) begin
            res_status_q <= ST_OK;
            res_found_q  <= FIND_W'(ptr_q - CNT_W'(1));
            state_q      <= S_FIN;
          end else if (ptr_q == count_q) begin
            res_status_q <= ST_NOTFOUND;
            state_q      <= S_FIN;
          end else begin
            ptr_q <= ptr_q + CNT_W'(1);
          end
        end
        S_FIN: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_value_q  <= res_value_q;
            out_found_q  <= res_found_q;
            out_fill_q   <= FILL_W'(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_value   = $signed(out_value_q);
  assign rsp_o.found_index = out_found_q;
  assign rsp_o.fill_count  = out_fill_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_i.ready)
    else $error("ready while a request is in work");

  a_value_only_on_deq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> (rsp_o.out_value == '0))
    else $error("head value on a failed request");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_FULL) |-> (rsp_o.fill_count == FILL_W'(DEPTH)))
    else $error("full status with free slots");

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for shifting_fifo_with_search_unit
// Sends enqueue, dequeue, search and update words, first a directed set at
// the edges of the queue and of the value range, then random bursts that
// fill and drain the queue. Each accepted request runs through a local queue
// model, and every response is checked field by field in order, with random
// stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import sfs_pkg::*;

  localparam int RANDOM_REQS  = 1300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int CALM_FIRST   = 1500;
  localparam int CALM_LAST    = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    req_kind_e          kind;
    logic signed [31:0] value;
    logic [2:0]         index;
  } request_t;

  typedef struct {
    status_e     status;
    logic [31:0] value;
    logic [2:0]  found;
    logic [3:0]  fill;
  } response_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               req_valid = 1'b0;
  req_kind_e          req_kind  = REQ_ENQ;
  logic signed [31:0] req_value = '0;
  logic [2:0]         req_index = '0;
  logic               rsp_ready = 1'b0;

  request_t  pending_reqs[$];
  response_t expected_rsps[$];

  logic [31:0] model_slots[DEPTH];
  int          model_fill = 0;

  logic [31:0] value_pool[16];
  int          gen_fill = 0;
  int          cycle_count = 0;
  int          fail_count = 0;

  sfs_req_if req_bus ();
  sfs_rsp_if rsp_bus ();

  assign req_bus.valid     = req_valid;
  assign req_bus.req_type  = req_kind;
  assign req_bus.req_value = req_value;
  assign req_bus.req_index = req_index;
  assign rsp_bus.ready     = rsp_ready;

  shifting_fifo_with_search_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic bit take_break();
    if (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) return 1'b0;
    return $urandom_range(99) < 20;
  endfunction

  // Apply one request to the queue model and return the response it yields.
  function automatic response_t queue_response(request_t r);
    response_t rsp;
    rsp.status = ST_OK;
    rsp.value  = '0;
    rsp.found  = '0;
    case (r.kind)
      REQ_ENQ: begin
        if (model_fill >= DEPTH) rsp.status = ST_FULL;
        else begin
          model_slots[model_fill] = r.value;
          model_fill++;
        end
      end
      REQ_DEQ: begin
        if (model_fill == 0) rsp.status = ST_EMPTY;
        else begin
          rsp.value = model_slots[0];
          for (int i = 0; i + 1 < model_fill; i++) model_slots[i] = model_slots[i + 1];
          model_fill--;
        end
      end
      REQ_SRCH: begin
        rsp.status = ST_NOTFOUND;
        for (int i = 0; i < model_fill; i++) begin
          if (model_slots[i] == r.value) begin
            rsp.status = ST_OK;
            rsp.found  = i[2:0];
            break;
          end
        end
      end
      default: begin
        if (r.index >= model_fill) rsp.status = ST_BADINDEX;
        else model_slots[r.index] = r.value;
      end
    endcase
    rsp.fill = model_fill[3:0];
    return rsp;
  endfunction

  task automatic push_req(req_kind_e kind, logic [31:0] value, logic [2:0] index);
    request_t r;
    r.kind  = kind;
    r.value = value;
    r.index = index;
    pending_reqs.push_back(r);
    if (kind == REQ_ENQ && gen_fill < DEPTH) gen_fill++;
    if (kind == REQ_DEQ && gen_fill > 0) gen_fill--;
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 70) return value_pool[4'($urandom_range(15))];
    return $urandom;
  endfunction

  // Driver: hold the word until accepted, then advance.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_bus.ready) begin
      if (req_valid) begin
        request_t done;
        done.kind  = req_kind;
        done.value = req_value;
        done.index = req_index;
        expected_rsps.push_back(queue_response(done));
      end
      if (pending_reqs.size() != 0 && !take_break()) begin
        request_t nxt;
        nxt = pending_reqs.pop_front();
        req_valid <= 1'b1;
        req_kind  <= nxt.kind;
        req_value <= nxt.value;
        req_index <= nxt.index;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) rsp_ready <= 1'b0;
    else rsp_ready <= !take_break();
  end

  // Monitor: check each accepted response against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      response_t want;
      if (expected_rsps.size() == 0) begin
        $error("response word with none expected: status %0d", rsp_bus.status);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
          fail_count++;
        end
        if (rsp_bus.out_value !== want.value) begin
          $error("out_value: expected %h, got %h", want.value, rsp_bus.out_value);
          fail_count++;
        end
        if (rsp_bus.found_index !== want.found) begin
          $error("found_index: expected %0d, got %0d", want.found, rsp_bus.found_index);
          fail_count++;
        end
        if (rsp_bus.fill_count !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, rsp_bus.fill_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int        roll;
    int        burst_mode;
    req_kind_e kind;
    logic [2:0] idx;

    for (int i = 0; i < DEPTH; i++) model_slots[i] = '0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom;

    // Empty queue cases.
    push_req(REQ_DEQ, 32'h0, 3'd0);
    push_req(REQ_SRCH, 32'h0, 3'd0);
    push_req(REQ_UPD, 32'h1234_5678, 3'd0);
    // Fill to the top with extreme values and a duplicate.
    push_req(REQ_ENQ, 32'h8000_0000, 3'd0);
    push_req(REQ_ENQ, 32'h7FFF_FFFF, 3'd7);
    push_req(REQ_ENQ, 32'h0000_0000, 3'd0);
    push_req(REQ_ENQ, 32'hFFFF_FFFF, 3'd0);
    push_req(REQ_ENQ, 32'h7FFF_FFFF, 3'd0);
    push_req(REQ_ENQ, 32'h0000_0005, 3'd0);
    push_req(REQ_ENQ, 32'h5555_5555, 3'd0);
    push_req(REQ_ENQ, 32'hAAAA_AAAA, 3'd0);
    push_req(REQ_ENQ, 32'h0000_0001, 3'd0);
    // Search: first of duplicates, last slot, head, miss.
    push_req(REQ_SRCH, 32'h7FFF_FFFF, 3'd0);
    push_req(REQ_SRCH, 32'hAAAA_AAAA, 3'd0);
    push_req(REQ_SRCH, 32'h8000_0000, 3'd0);
    push_req(REQ_SRCH, 32'h0000_3039, 3'd0);
    // Update at both ends, then past the tail after a dequeue.
    push_req(REQ_UPD, 32'h1234_5678, 3'd7);
    push_req(REQ_UPD, 32'hFFFF_FFFF, 3'd0);
    push_req(REQ_DEQ, 32'h0, 3'd0);
    push_req(REQ_UPD, 32'h0BAD_0BAD, 3'd7);
    push_req(REQ_SRCH, 32'h1234_5678, 3'd0);
    push_req(REQ_DEQ, 32'h0, 3'd0);
    push_req(REQ_SRCH, 32'hFFFF_FFFF, 3'd0);

    burst_mode = 0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) burst_mode = $urandom_range(2);
      roll = $urandom_range(99);
      if (roll < 8) begin
        push_req(req_kind_e'($urandom_range(3)), $urandom, 3'($urandom_range(7)));
        continue;
      end
      roll = $urandom_range(99);
      case (burst_mode)
        0:       kind = roll < 50 ? REQ_ENQ : roll < 65 ? REQ_DEQ : roll < 85 ? REQ_SRCH : REQ_UPD;
        1:       kind = roll < 15 ? REQ_ENQ : roll < 55 ? REQ_DEQ : roll < 80 ? REQ_SRCH : REQ_UPD;
        default: kind = roll < 30 ? REQ_ENQ : roll < 55 ? REQ_DEQ : roll < 80 ? REQ_SRCH : REQ_UPD;
      endcase
      if (kind == REQ_UPD && gen_fill > 0 && $urandom_range(99) < 80)
        idx = 3'($urandom_range(gen_fill - 1));
      else
        idx = 3'($urandom_range(7));
      push_req(kind, pick_value(), idx);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
